/* hw/rtl/bf3m_pkg.sv */
// ----------------------------------------------------------------------------
// bf3m_pkg
// Shared types and constants for the 3x3 box filter mean unit.
// ----------------------------------------------------------------------------
package bf3m_pkg;

   localparam int MAX_WIDTH_DEF = 32;

   // geometry limits and register reset values
   localparam logic [5:0]  WIDTH_MIN    = 6'd3;
   localparam logic [11:0] HEIGHT_MIN   = 12'd3;
   localparam logic [5:0]  WIDTH_RESET  = 6'd32;
   localparam logic [11:0] HEIGHT_RESET = 12'd32;

   // (x * RECIP_MULT) >> RECIP_SHIFT == x / 9, exact for x < 2**21
   localparam logic [19:0] RECIP_MULT  = 20'd932068;
   localparam int          RECIP_SHIFT = 23;
   localparam logic [19:0] ROUND_BIAS  = 20'd4;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_WIN,
      KIND_MEAN,
      KIND_FLUSH_HI,
      KIND_FLUSH_LO
   } item_kind_type;

   typedef enum logic {
      SEQ_STREAM,
      SEQ_FLUSH
   } seq_state_type;

   // clamped frame geometry from the register block
   typedef struct packed {
      logic [5:0]  width;
      logic [11:0] height;
   } geom_type;

   // word leaving the window stage
   typedef struct packed {
      logic        is_mean;
      logic [7:0]  pass;
      logic [11:0] sum;
      logic        frame_end;
   } bw_type;

   // word leaving the scaling stage
   typedef struct packed {
      logic        is_mean;
      logic [7:0]  pass;
      logic [15:0] mean;
      logic        frame_end;
   } cw_type;

endpackage

/* hw/rtl/bf3m_line_ram.sv */
// ----------------------------------------------------------------------------
// bf3m_line_ram
// Line buffer: one entry per column, {two rows up, one row up}.
// ----------------------------------------------------------------------------
module bf3m_line_ram
   import bf3m_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         ren,
   input  logic [$clog2(MAX_WIDTH)-1:0] raddr,
   output logic [15:0]                  rdata,
   input  logic                         wen,
   input  logic [$clog2(MAX_WIDTH)-1:0] waddr,
   input  logic [15:0]                  wdata
);

   logic [15:0] mem [MAX_WIDTH];
   logic [15:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
   end

   // write-first: a read of the entry written in the same cycle sees new data
   always_ff @(posedge clock) begin
      if (ren) begin
         if (wen && (waddr == raddr)) begin
            rdata_ff <= wdata;
         end else begin
            rdata_ff <= mem[raddr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/bf3m_csr.sv */
// ----------------------------------------------------------------------------
// bf3m_csr
// APB register block: frame width and height, clamped for the datapath.
// ----------------------------------------------------------------------------
module bf3m_csr
   import bf3m_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output geom_type    geom
);

   localparam logic       REG_FRAME_WIDTH  = 1'b0;
   localparam logic       REG_FRAME_HEIGHT = 1'b1;
   localparam logic [5:0] WIDTH_MAX        = 6'(MAX_WIDTH);

   logic [5:0]  width_ff,  width_in;
   logic [11:0] height_ff, height_in;
   logic        wr_stb;

   assign csr_pready = 1'b1;
   assign wr_stb     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_stb) begin
         unique case (csr_paddr[2])
            REG_FRAME_WIDTH:  width_in  = csr_pwdata[5:0];
            REG_FRAME_HEIGHT: height_in = csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_FRAME_WIDTH:  csr_prdata = {26'd0, width_ff};
         REG_FRAME_HEIGHT: csr_prdata = {20'd0, height_ff};
         default:          csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (width_ff < WIDTH_MIN) begin
         geom.width = WIDTH_MIN;
      end else if (width_ff > WIDTH_MAX) begin
         geom.width = WIDTH_MAX;
      end else begin
         geom.width = width_ff;
      end
      geom.height = (height_ff < HEIGHT_MIN) ? HEIGHT_MIN : height_ff;
   end

endmodule

/* hw/rtl/bf3m_mean_scale.sv */
// ----------------------------------------------------------------------------
// bf3m_mean_scale
// Scaling stage: (sum*256 + 4) / 9 by reciprocal multiply, registered.
// ----------------------------------------------------------------------------
module bf3m_mean_scale
   import bf3m_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   adv,
   input  logic   in_valid,
   input  bw_type in_word,
   output logic   out_valid,
   output cw_type out_word
);

   logic        valid_ff;
   logic [19:0] dividend;
   logic [39:0] prod_in, prod_ff;
   logic        is_mean_ff;
   logic [7:0]  pass_ff;
   logic        frame_end_ff;

   assign dividend = {in_word.sum, 8'h00} + ROUND_BIAS;
   assign prod_in  = dividend * RECIP_MULT;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         prod_ff      <= prod_in;
         is_mean_ff   <= in_word.is_mean;
         pass_ff      <= in_word.pass;
         frame_end_ff <= in_word.frame_end;
      end
   end

   assign out_valid          = valid_ff;
   assign out_word.is_mean   = is_mean_ff;
   assign out_word.pass      = pass_ff;
   assign out_word.mean      = prod_ff[RECIP_SHIFT+15:RECIP_SHIFT];
   assign out_word.frame_end = frame_end_ff;

endmodule

/* hw/rtl/box_filter_3x3_mean_unit.sv */
// ----------------------------------------------------------------------------
// box_filter_3x3_mean_unit
// Streaming 3x3 box filter, unsigned Q8.8 mean out, raster order.
// ----------------------------------------------------------------------------
//  channel  | ports                              | carries
//  ---------+------------------------------------+------------------------------
//  req      | req_valid/req_ready, req_pixel     | one 8-bit pixel per word
//  rsp      | rsp_valid/rsp_ready, rsp_mean_value| Q8.8 result, frame_end flag
//           | rsp_frame_end                      |
//  csr      | csr_psel..csr_pready (APB)         | 0x0 frame_width, 0x4 height
//
//  One pixel per cycle outside a flush and rsp stall; a word passes from req to
//  rsp via line buffer read, window update, reciprocal multiply, output register.
//  The last pixel of a frame starts a flush of W+1 words read back from the
//  line buffer, one per cycle unless rsp stalls; req_ready is low meanwhile.
//  Reset clears the pipeline valids, position, sequencer and window; the
//  line buffer keeps its contents and needs no clearing pass.
//  A stall on rsp fills the pipeline bubbles first, then backs up to req.
// ----------------------------------------------------------------------------
module box_filter_3x3_mean_unit
   import bf3m_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // pixel input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_pixel,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_mean_value,
   output logic        rsp_frame_end,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CNT_W = $clog2(MAX_WIDTH + 1);

   // ---- geometry -----------------------------------------------------------
   geom_type         geom;
   logic [CNT_W-1:0] w_eff;
   logic [11:0]      h_eff;

   bf3m_csr #(.MAX_WIDTH(MAX_WIDTH)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .geom        (geom)
   );

   // clamped width never exceeds MAX_WIDTH, so it fits CNT_W bits
   assign w_eff = CNT_W'(geom.width);
   assign h_eff = geom.height;

   // ---- handshake chain: each stage moves when the next has room -----------
   logic adv_a, adv_b, adv_c, adv_d;
   logic a_v_ff, b_v_ff, c_v;
   logic rsp_valid_ff;

   assign adv_d = !rsp_valid_ff || rsp_ready;
   assign adv_c = !c_v || adv_d;
   assign adv_b = !b_v_ff || adv_c;
   assign adv_a = !a_v_ff || adv_b;

   // ---- position of the next pixel ----------------------------------------
   logic [CNT_W-1:0] col_ff, col_in, col_cur, col_step;
   logic [11:0]      row_ff, row_in, row_cur;
   logic             is_last;
   logic             accept;
   item_kind_type    kind_cur;

   // a geometry write that leaves the position outside the frame restarts it
   always_comb begin
      if ((col_ff >= w_eff) || (row_ff >= h_eff)) begin
         col_cur = '0;
         row_cur = '0;
      end else begin
         col_cur = col_ff;
         row_cur = row_ff;
      end
   end

   assign col_step = col_cur + CNT_W'(1);
   assign is_last  = (row_cur == (h_eff - 12'd1)) && (col_step == w_eff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (is_last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_step >= w_eff) begin
            col_in = '0;
            row_in = row_cur + 12'd1;
         end else begin
            col_in = col_step;
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // what the pixel produces: nothing in row 0 or at the start of row 1,
   // a mean inside the frame, otherwise the centre pixel passed through
   always_comb begin
      priority if (row_cur == 12'd0) begin
         kind_cur = KIND_NONE;
      end else if (col_cur == '0) begin
         kind_cur = (row_cur >= 12'd2) ? KIND_WIN : KIND_NONE;
      end else if ((row_cur >= 12'd2) && (col_cur >= CNT_W'(2))) begin
         kind_cur = KIND_MEAN;
      end else begin
         kind_cur = KIND_WIN;
      end
   end

   // ---- issue sequencer: pixels, or flush reads at end of frame -----------
   seq_state_type    state_ff, state_in;
   logic [CNT_W-1:0] fcnt_ff, fcnt_in, fcnt_dec, w_last;
   logic             issue;
   item_kind_type    iss_kind;
   logic [COL_W-1:0] iss_addr;
   logic             iss_end;

   assign w_last   = w_eff - CNT_W'(1);
   assign fcnt_dec = fcnt_ff - CNT_W'(1);

   assign req_ready = adv_a && (state_ff == SEQ_STREAM);
   assign accept    = req_valid && req_ready;
   assign issue     = adv_a && ((state_ff == SEQ_FLUSH) || req_valid);

   always_comb begin
      state_in = state_ff;
      fcnt_in  = fcnt_ff;
      iss_kind = kind_cur;
      iss_addr = col_cur[COL_W-1:0];
      iss_end  = 1'b0;
      unique case (state_ff)
         SEQ_STREAM: begin
            if (accept && is_last) begin
               state_in = SEQ_FLUSH;
               fcnt_in  = '0;
            end
         end
         SEQ_FLUSH: begin
            // first the last column two rows up, then the whole row one up
            if (fcnt_ff == '0) begin
               iss_kind = KIND_FLUSH_HI;
               iss_addr = w_last[COL_W-1:0];
            end else begin
               iss_kind = KIND_FLUSH_LO;
               iss_addr = fcnt_dec[COL_W-1:0];
            end
            iss_end = (fcnt_ff == w_eff);
            if (issue) begin
               if (iss_end) begin
                  state_in = SEQ_STREAM;
                  fcnt_in  = '0;
               end else begin
                  fcnt_in = fcnt_ff + CNT_W'(1);
               end
            end
         end
         default: state_in = SEQ_STREAM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_STREAM;
         fcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fcnt_ff  <= fcnt_in;
      end
   end

   // ---- stage A: line buffer read in flight --------------------------------
   item_kind_type    a_kind_ff;
   logic [7:0]       a_px_ff;
   logic [COL_W-1:0] a_col_ff;
   logic             a_end_ff;
   logic [15:0]      rd_data;
   logic             a_pix, a_move, lb_wen;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (adv_a) begin
         a_v_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         a_kind_ff <= iss_kind;
         a_px_ff   <= req_pixel;
         a_col_ff  <= iss_addr;
         a_end_ff  <= iss_end;
      end
   end

   assign a_pix  = (a_kind_ff == KIND_NONE) || (a_kind_ff == KIND_WIN) ||
                   (a_kind_ff == KIND_MEAN);
   assign a_move = a_v_ff && adv_b;
   assign lb_wen = a_move && a_pix;

   // consecutive pixels always hit different columns; the only same-entry
   // overlap is the first flush read, covered by the write-first bypass
   bf3m_line_ram #(.MAX_WIDTH(MAX_WIDTH)) u_line_ram (
      .clock (clock),
      .ren   (issue),
      .raddr (iss_addr),
      .rdata (rd_data),
      .wen   (lb_wen),
      .waddr (a_col_ff),
      .wdata ({rd_data[7:0], a_px_ff})
   );

   // ---- window update and sum (A -> B) ------------------------------------
   logic [7:0]  win_ff [9];
   logic [11:0] win_sum;
   bw_type      b_in, b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= 8'd0;
         end
      end else if (lb_wen) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r*3+0] <= win_ff[r*3+1];
            win_ff[r*3+1] <= win_ff[r*3+2];
         end
         win_ff[2] <= rd_data[15:8];
         win_ff[5] <= rd_data[7:0];
         win_ff[8] <= a_px_ff;
      end
   end

   // sum of the window after the shift
   assign win_sum = {4'd0, win_ff[1]} + {4'd0, win_ff[2]} + {4'd0, win_ff[4]} +
                    {4'd0, win_ff[5]} + {4'd0, win_ff[7]} + {4'd0, win_ff[8]} +
                    {4'd0, rd_data[15:8]} + {4'd0, rd_data[7:0]} + {4'd0, a_px_ff};

   always_comb begin
      b_in.is_mean   = (a_kind_ff == KIND_MEAN);
      b_in.sum       = win_sum;
      b_in.frame_end = a_end_ff;
      unique case (a_kind_ff)
         KIND_FLUSH_HI: b_in.pass = rd_data[15:8];
         KIND_FLUSH_LO: b_in.pass = rd_data[7:0];
         default:       b_in.pass = win_ff[5];  // centre after the shift
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (adv_b) begin
         b_v_ff <= a_v_ff && (a_kind_ff != KIND_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (a_move) begin
         b_ff <= b_in;
      end
   end

   // ---- stage C: reciprocal multiply ----------------------------------------
   cw_type c_word;

   bf3m_mean_scale u_mean_scale (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv_c),
      .in_valid  (b_v_ff),
      .in_word   (b_ff),
      .out_valid (c_v),
      .out_word  (c_word)
   );

   // ---- stage D: output register ------------------------------------------
   logic [15:0] mean_ff;
   logic        frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_d) begin
         rsp_valid_ff <= c_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_d && c_v) begin
         mean_ff      <= c_word.is_mean ? c_word.mean : {c_word.pass, 8'h00};
         frame_end_ff <= c_word.frame_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean_value = mean_ff;
   assign rsp_frame_end  = frame_end_ff;

endmodule

/* dv/box_filter_3x3_mean_checker.sv */
// ----------------------------------------------------------------------------
// box_filter_3x3_mean_checker
// Watches the pixel, result and register ports of the box filter, predicts
// every smoothed word from its own line buffers and 3x3 window, and compares
// each result word in order against the oldest prediction.
// ----------------------------------------------------------------------------
module box_filter_3x3_mean_checker
   import bf3m_pkg::*;
#(
   parameter int         MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter logic [2:0] WIDTH_ADDR  = 3'h0,
   parameter logic [2:0] HEIGHT_ADDR = 3'h4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_pixel,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_mean_value,
   input  logic        rsp_frame_end,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] mean_value;
      logic        frame_end;
   } smooth_word_type;

   smooth_word_type expected_smooth[$];
   smooth_word_type got_word;
   smooth_word_type want_word;

   logic [7:0]  prev_line      [MAX_WIDTH];
   logic [7:0]  prev_prev_line [MAX_WIDTH];
   logic [7:0]  nbhd           [9];
   logic [5:0]  col_at;
   logic [11:0] row_at;
   logic [5:0]  cfg_width;
   logic [11:0] cfg_height;
   int          errors;

   function automatic void expect_word(logic [15:0] value, logic is_last);
      expected_smooth.push_back(smooth_word_type'{value, is_last});
   endfunction

   // one pixel in: shift the window, update the line buffers, queue results
   function automatic void smooth_pixel(logic [7:0] px);
      logic [5:0]  w;
      logic [11:0] h;
      logic [5:0]  c;
      logic [11:0] r;
      logic [7:0]  wrapped_centre;
      int unsigned total;
      w = cfg_width;
      if (w < WIDTH_MIN) w = WIDTH_MIN;
      if (w > MAX_WIDTH) w = 6'(MAX_WIDTH);
      h = (cfg_height < HEIGHT_MIN) ? HEIGHT_MIN : cfg_height;
      c = col_at;
      r = row_at;
      if (c >= w || r >= h) begin
         c = '0;
         r = '0;
      end
      // centre of the newest column: last pixel of the row above at col 0
      wrapped_centre = nbhd[5];
      for (int k = 0; k < 3; k++) begin
         nbhd[3*k]     = nbhd[3*k + 1];
         nbhd[3*k + 1] = nbhd[3*k + 2];
      end
      nbhd[2] = prev_prev_line[c];
      nbhd[5] = prev_line[c];
      nbhd[8] = px;
      prev_prev_line[c] = prev_line[c];
      prev_line[c]      = px;
      if (r >= 1) begin
         if (c == 0) begin
            if (r >= 2) expect_word({wrapped_centre, 8'h00}, 1'b0);
         end else if (r >= 2 && c >= 2) begin
            total = 0;
            for (int k = 0; k < 9; k++) total += nbhd[k];
            expect_word(16'((total * 256 + 4) / 9), 1'b0);
         end else begin
            expect_word({nbhd[4], 8'h00}, 1'b0);
         end
      end
      if (r == h - 1 && c == w - 1) begin
         // flush: last pixel of row h-2, then the whole last row
         expect_word({prev_prev_line[w - 1], 8'h00}, 1'b0);
         for (int k = 0; k < w; k++) expect_word({prev_line[k], 8'h00}, k == w - 1);
         col_at = '0;
         row_at = '0;
      end else begin
         c++;
         if (c >= w) begin
            c = '0;
            r++;
         end
         col_at = c;
         row_at = r;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_smooth.delete();
         foreach (prev_line[k]) begin
            prev_line[k]      = '0;
            prev_prev_line[k] = '0;
         end
         foreach (nbhd[k]) nbhd[k] = '0;
         col_at     = '0;
         row_at     = '0;
         cfg_width  = WIDTH_RESET;
         cfg_height = HEIGHT_RESET;
         errors     = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == WIDTH_ADDR) cfg_width = csr_pwdata[5:0];
            else if (csr_paddr == HEIGHT_ADDR) cfg_height = csr_pwdata[11:0];
         end
         if (req_valid && req_ready) smooth_pixel(req_pixel);
         if (rsp_valid && rsp_ready) begin
            got_word = smooth_word_type'{rsp_mean_value, rsp_frame_end};
            if (expected_smooth.size() == 0) begin
               errors++;
               $display("%0t ns: result word with none expected: expected none, got %h/%b",
                        $time, got_word.mean_value, got_word.frame_end);
            end else begin
               want_word = expected_smooth.pop_front();
               if (got_word.mean_value !== want_word.mean_value) begin
                  errors++;
                  $display("%0t ns: mean_value expected %h, got %h",
                           $time, want_word.mean_value, got_word.mean_value);
               end
               if (got_word.frame_end !== want_word.frame_end) begin
                  errors++;
                  $display("%0t ns: frame_end expected %b, got %b",
                           $time, want_word.frame_end, got_word.frame_end);
               end
            end
         end
      end
      mismatch_count  <= errors;
      results_pending <= expected_smooth.size();
   end

endmodule

/* dv/tb_box_filter_3x3_mean_unit.sv */
// ----------------------------------------------------------------------------
// tb_box_filter_3x3_mean_unit
// Drives frames of pixels and register writes into the 3x3 box filter and
// lets the checker beside it compare every smoothed word. A short directed
// run covers full-scale and zero frames and a frame restart; random phases
// then vary geometry, content, idling and cut frames; a clean tail runs the
// widest frame and then a taller narrow one.
// ----------------------------------------------------------------------------
module tb_box_filter_3x3_mean_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import bf3m_pkg::*;

   localparam int         HALF_PERIOD     = 10;
   localparam int         RESET_CYCLES    = 5;
   localparam int         RANDOM_ITEMS    = 160;
   localparam int         GAP_MAX         = 12;
   // covers the 4-stage pipe plus a full receiver stall
   localparam int         DRAIN_CYCLES    = 24;
   localparam int         END_CYCLES      = 64;
   localparam int         WATCHDOG_LIMIT  = 2000;
   localparam int         TAIL_HEIGHT     = 24;
   localparam logic [2:0] CSR_WIDTH_ADDR  = 3'h0;
   localparam logic [2:0] CSR_HEIGHT_ADDR = 3'h4;

   // frame content
   typedef enum int {
      PAT_NOISE,
      PAT_BLACK,
      PAT_WHITE,
      PAT_CHECKER,
      PAT_RAMP
   } pattern_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_pixel;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_mean_value;
   logic        rsp_frame_end;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          mismatch_count;
   int          results_pending;

   bit gaps_on    = 1'b0;  // sender may drop valid between words
   bit stalls_on  = 1'b0;  // receiver may drop ready
   int stall_left = 0;
   int idle_cycles = 0;
   int width_raw;          // register contents as last written
   int height_raw;
   int sent_pixels = 0;

   box_filter_3x3_mean_unit uut (.*);

   box_filter_3x3_mean_checker #(
      .WIDTH_ADDR  (CSR_WIDTH_ADDR),
      .HEIGHT_ADDR (CSR_HEIGHT_ADDR)
   ) chk (.*);

   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   // receiver: ready drops in random bursts while stalls are on
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready  = 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, GAP_MAX - 1);
         rsp_ready  = 1'b0;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // watchdog: any accepted word or register access counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: nothing accepted for %0d cycles, %0d results outstanding",
                  $time, idle_cycles, results_pending);
         $display("box_filter_3x3_mean_unit test failed");
         $finish;
      end
   end

   // geometry the block will actually use, after clamping
   function automatic int eff_width();
      if (width_raw < WIDTH_MIN) return WIDTH_MIN;
      if (width_raw > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_raw;
   endfunction

   function automatic int eff_height();
      if (height_raw < HEIGHT_MIN) return HEIGHT_MIN;
      return height_raw;
   endfunction

   // APB write: setup cycle, then access cycle until pready
   task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // junk fills the unused upper bits so the field masking gets exercised
   task automatic set_width(input int value, input bit junk);
      logic [31:0] data;
      data       = junk ? 32'($urandom) : 32'h0;
      data[5:0]  = value[5:0];
      write_reg(CSR_WIDTH_ADDR, data);
      width_raw  = value[5:0];
   endtask

   task automatic set_height(input int value, input bit junk);
      logic [31:0] data;
      data        = junk ? 32'($urandom) : 32'h0;
      data[11:0]  = value[11:0];
      write_reg(CSR_HEIGHT_ADDR, data);
      height_raw  = value[11:0];
   endtask

   // one pixel word; valid stays up afterwards unless a gap is taken next time
   task automatic send_pixel(input logic [7:0] px);
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, GAP_MAX)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_pixel = px;
      do @(posedge clock); while (!req_ready);
      sent_pixels++;
   endtask

   // raster indices first..last-1 of a frame w pixels wide
   task automatic send_frame(input int w, input int first, input int last,
                             input pattern_type pat);
      int          r;
      int          c;
      logic [7:0]  px;
      for (int i = first; i < last; i++) begin
         r = i / w;
         c = i % w;
         unique case (pat)
            PAT_BLACK:   px = 8'h00;
            PAT_WHITE:   px = 8'hFF;
            PAT_CHECKER: px = ((r + c) % 2 != 0) ? 8'hFF : 8'h00;
            PAT_RAMP:    px = 8'(i * 37);
            default:     px = 8'($urandom_range(0, 255));
         endcase
         send_pixel(px);
      end
   endtask

   // drop valid, let every expected word out, then let no-result words drain
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int          ew;
      int          eh;
      int          pick;
      int          frames;
      int          cut;
      int          cut_row;
      int          cut_col;
      int          frame_px;
      int          random_start;
      pattern_type pat;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_pixel   = 8'h00;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = CSR_WIDTH_ADDR;
      csr_pwdata  = 32'h0;
      width_raw   = WIDTH_RESET;
      height_raw  = HEIGHT_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed ---
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      // smallest frame, all white: the single mean hits full scale
      set_width(3, 1'b0);
      set_height(3, 1'b0);
      send_frame(3, 0, 9, PAT_WHITE);
      wait_idle();
      // tall frame cut in row 3; height 0 clamps to 3, so the position is
      // now outside the frame and the next word starts a fresh one
      set_height(4095, 1'b0);
      send_frame(3, 0, 10, PAT_CHECKER);
      wait_idle();
      set_height(0, 1'b0);
      send_frame(3, 0, 9, PAT_BLACK);
      wait_idle();

      // --- random phases ---
      random_start = sent_pixels;
      while (sent_pixels - random_start < RANDOM_ITEMS) begin
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) != 0) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)      set_width($urandom_range(0, 2), 1'b1);   // clamps up
            else if (pick == 1) set_width($urandom_range(33, 63), 1'b1); // clamps down
            else if (pick == 2) set_width(MAX_WIDTH_DEF, 1'b1);
            else                set_width($urandom_range(3, 10), 1'b1);
         end
         // keep wide frames short
         if ($urandom_range(0, 4) != 0)
            set_height((eff_width() > 10) ? $urandom_range(0, 4) : $urandom_range(0, 9),
                       1'b1);
         frames = $urandom_range(1, 2);
         for (int f = 0; f < frames; f++) begin
            ew       = eff_width();
            eh       = eff_height();
            frame_px = ew * eh;
            pat      = pattern_type'($urandom_range(0, 4));
            if ($urandom_range(0, 5) == 0) begin
               // cut the frame, then shrink the geometry under the position
               cut     = $urandom_range(1, frame_px - 1);
               send_frame(ew, 0, cut, pat);
               wait_idle();
               cut_row = cut / ew;
               cut_col = cut % ew;
               if (cut_row >= 3)
                  set_height($urandom_range(0, cut_row), 1'b1);
               else if (cut_col >= 3)
                  set_width($urandom_range(0, cut_col), 1'b1);
               else
                  send_frame(ew, cut, frame_px, pat);  // too early to restart
            end else begin
               send_frame(ew, 0, frame_px, pat);
            end
         end
         wait_idle();
      end

      // --- tail, no idling: widest frame, then a taller narrow one ---
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      set_width(63, 1'b1);
      set_height(3, 1'b1);
      send_frame(eff_width(), 0, eff_width() * eff_height(), PAT_NOISE);
      wait_idle();
      set_width(3, 1'b0);
      set_height(TAIL_HEIGHT, 1'b1);
      send_frame(eff_width(), 0, eff_width() * eff_height(), PAT_NOISE);

      wait_idle();
      repeat (END_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && results_pending == 0)
         $display("box_filter_3x3_mean_unit test passed");
      else
         $display("box_filter_3x3_mean_unit test failed");
      $finish;
   end

endmodule
